// ----- rtl/vpg_pkg.sv -----
// ----------------------------------------------------------------------------
// vpg_pkg
// Types and constants shared by the velocity profile generator modules.
// ----------------------------------------------------------------------------
package vpg_pkg;

  // Width of every Q15.16 magnitude handled by the block.
  localparam int unsigned VelW = 31;
  // Width of the shared multiplier operands and of its product.
  localparam int unsigned MulW = 32;
  localparam int unsigned ProdW = 2 * MulW;
  // Dividend of the deceleration division: half of a squared difference.
  localparam int unsigned DivdW = 2 * VelW - 1;
  localparam int unsigned TimeW = 16;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegMaxVel = 2'd0;
  localparam logic [1:0] RegFloorVel = 2'd1;
  localparam logic [1:0] RegAccel = 2'd2;
  localparam logic [1:0] RegDecel = 2'd3;

  localparam logic [VelW-1:0] MaxVelRst = 31'd32768;
  localparam logic [VelW-1:0] FloorVelRst = 31'd3277;
  localparam logic [VelW-1:0] AccelRst = 31'd6554;
  localparam logic [VelW-1:0] DecelRst = 31'd6554;

  typedef struct packed {
    logic [VelW-1:0]  remaining_distance;
    logic [TimeW-1:0] time_step;
    logic             restart;
  } in_beat_t;

  typedef struct packed {
    logic [VelW-1:0] velocity_cmd;
    logic            decelerating;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    StIdle,
    StBrkA,
    StBrkB,
    StBrkC,
    StAcc,
    StSqV,
    StSqF,
    StDiff,
    StCap,
    StDiv,
    StStep,
    StApply,
    StDone
  } state_e;

endpackage

// ----- rtl/velocity_profile_generator.sv -----
// ----------------------------------------------------------------------------
// velocity_profile_generator
// Trapezoidal one-axis velocity profile in Q15.16, computed by a sequencer
// around one shared multiplier and an iterative divider.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                Beat
//   in        input      in_valid_i / in_ready_o  in_beat_t (distance, dt, restart)
//   out       output     out_valid_o / out_ready_i out_beat_t (velocity, decel flag)
//   config    input      APB psel/penable/pwrite  32-bit register write or read
//
// A tick runs the braking test (StBrkA to StBrkC), then StAcc when accelerating;
// when decelerating it squares, takes the difference and caps the deceleration,
// or runs the 31-step division, then StStep and StApply. One tick at a time.
// A finished beat waits in the output register while the next tick is taken.
// Reset clears velocity and the deceleration latch and loads register defaults.
// ----------------------------------------------------------------------------
module velocity_profile_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vpg_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vpg_pkg::out_beat_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned VelW = vpg_pkg::VelW;
  localparam int unsigned MulW = vpg_pkg::MulW;
  localparam int unsigned ProdW = vpg_pkg::ProdW;
  localparam int unsigned TimeW = vpg_pkg::TimeW;
  localparam int unsigned ScrW = 2 * VelW + 1;

  vpg_pkg::state_e state_q, state_d;

  logic [VelW-1:0]  maxv_q, floor_q, accel_q, decel_q;
  logic [VelW-1:0]  vel_q, vel_d;
  logic             lat_q, lat_d;
  logic [VelW-1:0]  rd_q, rd_d;
  logic [TimeW-1:0] dt_q, dt_d;
  logic [ScrW-1:0]  scr_q, scr_d;
  logic [VelW-1:0]  quo_q, quo_d;
  logic             neg_q, neg_d;
  logic             out_valid_q, out_valid_d;
  vpg_pkg::out_beat_t out_q, out_d;

  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  logic             div_start;
  vpg_pkg::div_status_t div_st;
  logic [VelW-1:0]  div_quo;

  logic [VelW-1:0]  dec;
  logic             cfg_wr;
  logic             out_free;
  logic [VelW-1:0]  step;
  logic [VelW:0]    vsum;
  logic [2*VelW-1:0] vsq, fsq, sqdiff;
  logic             sqneg;
  logic [VelW-1:0]  vnew;

  assign dec      = (decel_q == '0) ? VelW'(1) : decel_q;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = mul_p[VelW+TimeW-1:TimeW];
  assign vsum     = {1'b0, vel_q} + {1'b0, step};
  assign vsq      = scr_q[2*VelW-1:0];
  assign fsq      = mul_p[2*VelW-1:0];
  assign sqneg    = vsq < fsq;
  assign sqdiff   = sqneg ? (fsq - vsq) : (vsq - fsq);

  always_comb begin
    unique case (paddr[3:2])
      vpg_pkg::RegMaxVel:   prdata = {1'b0, maxv_q};
      vpg_pkg::RegFloorVel: prdata = {1'b0, floor_q};
      vpg_pkg::RegAccel:    prdata = {1'b0, accel_q};
      vpg_pkg::RegDecel:    prdata = {1'b0, decel_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxv_q  <= vpg_pkg::MaxVelRst;
      floor_q <= vpg_pkg::FloorVelRst;
      accel_q <= vpg_pkg::AccelRst;
      decel_q <= vpg_pkg::DecelRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        vpg_pkg::RegMaxVel:   maxv_q  <= pwdata[VelW-1:0];
        vpg_pkg::RegFloorVel: floor_q <= pwdata[VelW-1:0];
        vpg_pkg::RegAccel:    accel_q <= pwdata[VelW-1:0];
        vpg_pkg::RegDecel:    decel_q <= pwdata[VelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    vel_d       = vel_q;
    lat_d       = lat_q;
    rd_d        = rd_q;
    dt_d        = dt_q;
    scr_d       = scr_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    vnew        = vel_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      vpg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rd_d = in_data_i.remaining_distance;
          dt_d = in_data_i.time_step;
          if (in_data_i.restart) begin
            vel_d = '0;
            lat_d = 1'b0;
          end
          state_d = vpg_pkg::StBrkA;
        end
      end
      vpg_pkg::StBrkA: begin
        mul_a   = {1'b0, vel_q} + {1'b0, floor_q};
        mul_b   = {1'b0, vel_q};
        state_d = vpg_pkg::StBrkB;
      end
      vpg_pkg::StBrkB: begin
        // Keep (v + floor) * v; rd <= that / dec is tested as rd * dec <= it.
        scr_d   = mul_p[ScrW-1:0];
        mul_a   = {1'b0, rd_q};
        mul_b   = {1'b0, dec};
        state_d = vpg_pkg::StBrkC;
      end
      vpg_pkg::StBrkC: begin
        mul_a = {1'b0, accel_q};
        mul_b = MulW'(dt_q);
        if (mul_p <= {{(ProdW-ScrW){1'b0}}, scr_q}) begin
          lat_d   = 1'b1;
          state_d = vpg_pkg::StSqV;
        end else begin
          state_d = vpg_pkg::StAcc;
        end
      end
      vpg_pkg::StAcc: begin
        vel_d   = (vsum > {1'b0, maxv_q}) ? maxv_q : vsum[VelW-1:0];
        state_d = lat_q ? vpg_pkg::StSqV : vpg_pkg::StDone;
      end
      vpg_pkg::StSqV: begin
        mul_a   = {1'b0, vel_q};
        mul_b   = {1'b0, vel_q};
        state_d = vpg_pkg::StSqF;
      end
      vpg_pkg::StSqF: begin
        scr_d   = mul_p[ScrW-1:0];
        mul_a   = {1'b0, floor_q};
        mul_b   = {1'b0, floor_q};
        state_d = vpg_pkg::StDiff;
      end
      vpg_pkg::StDiff: begin
        scr_d   = {2'b00, sqdiff[2*VelW-1:1]};
        neg_d   = sqneg;
        mul_a   = {1'b0, rd_q};
        mul_b   = {1'b0, dec};
        state_d = vpg_pkg::StCap;
      end
      vpg_pkg::StCap: begin
        // The quotient reaches dec exactly when the half difference reaches rd * dec.
        if (rd_q == '0 || {{(ProdW-ScrW){1'b0}}, scr_q} >= mul_p) begin
          quo_d   = dec;
          neg_d   = 1'b0;
          state_d = vpg_pkg::StStep;
        end else begin
          div_start = 1'b1;
          state_d   = vpg_pkg::StDiv;
        end
      end
      vpg_pkg::StDiv: begin
        if (div_st.done) begin
          quo_d   = div_quo;
          state_d = vpg_pkg::StStep;
        end
      end
      vpg_pkg::StStep: begin
        mul_a   = {1'b0, quo_q};
        mul_b   = MulW'(dt_q);
        state_d = vpg_pkg::StApply;
      end
      vpg_pkg::StApply: begin
        if (neg_q) begin
          vnew = vsum[VelW] ? {VelW{1'b1}} : vsum[VelW-1:0];
        end else begin
          vnew = (step >= vel_q) ? '0 : vel_q - step;
        end
        vel_d   = (vnew <= floor_q) ? floor_q : vnew;
        state_d = vpg_pkg::StDone;
      end
      vpg_pkg::StDone: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.velocity_cmd = vel_q;
          out_d.decelerating = lat_q;
          state_d            = vpg_pkg::StIdle;
        end
      end
      default: state_d = vpg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpg_pkg::StIdle;
      vel_q       <= '0;
      lat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vel_q       <= vel_d;
      lat_q       <= lat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    dt_q  <= dt_d;
    scr_q <= scr_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  vpg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scr_q[vpg_pkg::DivdW-1:0]),
    .divisor_i  (rd_q),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A decelerating beat never goes below the floor velocity.
  a_floor_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.decelerating |->
      out_data_o.velocity_cmd >= floor_q)
    else $error("decelerating velocity below floor");

  // An accelerating beat is always clamped at the ceiling.
  a_ceiling_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.decelerating |->
      out_data_o.velocity_cmd <= maxv_q)
    else $error("accelerating velocity above ceiling");

  // The divider starts only when idle and never with a zero divisor.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy && rd_q != '0)
    else $error("divider started busy or with zero divisor");

  // One tick at a time: after a beat is taken the input is closed.
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened straight after a beat");

endmodule

// ----- rtl/vpg_mul.sv -----
// ----------------------------------------------------------------------------
// vpg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module vpg_mul (
  input  logic                       clk_i,
  input  logic [vpg_pkg::MulW-1:0]   a_i,
  input  logic [vpg_pkg::MulW-1:0]   b_i,
  output logic [vpg_pkg::ProdW-1:0]  p_o
);

  logic [vpg_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {{vpg_pkg::MulW{1'b0}}, a_i} * {{vpg_pkg::MulW{1'b0}}, b_i};
  end

  assign p_o = p_q;

endmodule

// ----- rtl/vpg_div.sv -----
// ----------------------------------------------------------------------------
// vpg_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in VelW bits, so the partial remainder starts below the
// divisor.
// ----------------------------------------------------------------------------
module vpg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vpg_pkg::DivdW-1:0]   dividend_i,
  input  logic [vpg_pkg::VelW-1:0]    divisor_i,
  output vpg_pkg::div_status_t        status_o,
  output logic [vpg_pkg::VelW-1:0]    quotient_o
);

  localparam int unsigned Steps = vpg_pkg::VelW;
  localparam int unsigned CntW = $clog2(Steps);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [vpg_pkg::VelW-1:0] rem_q, rem_d;
  logic [vpg_pkg::VelW-1:0] low_q, low_d;
  logic [vpg_pkg::VelW-1:0] quo_q, quo_d;
  logic [vpg_pkg::VelW-1:0] dvs_q, dvs_d;
  logic [vpg_pkg::VelW:0]   trial;
  logic [vpg_pkg::VelW:0]   diff;
  logic                     fits;

  assign trial = {rem_q, low_q[vpg_pkg::VelW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps - 1);
      rem_d  = {1'b0, dividend_i[vpg_pkg::DivdW-1:vpg_pkg::VelW]};
      low_d  = dividend_i[vpg_pkg::VelW-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[vpg_pkg::VelW-1:0] : trial[vpg_pkg::VelW-1:0];
      low_d = {low_q[vpg_pkg::VelW-2:0], 1'b0};
      quo_d = {quo_q[vpg_pkg::VelW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule
